@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lfrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lfrs_pkg
// Widths, register codes and the structs that pass between the room cells
// and the scheduler control.
// ----------------------------------------------------------------------------
package lfrs_pkg;

  localparam int MAX_ROOMS  = 16;
  localparam int ROOM_BITS  = 4;
  localparam int TIME_BITS  = 56;
  localparam int IN_BITS    = 32;
  localparam int COUNT_BITS = 24;
  localparam int CFG_BITS   = 5;
  localparam int ADDR_BITS  = 3;

  localparam logic [CFG_BITS-1:0] ROOMS_RESET = CFG_BITS'(MAX_ROOMS);

  // word-select bit of paddr (byte address 4*i)
  localparam logic REG_ROOMS_IN_USE = 1'b0;

  // search word travelling down the chain of room cells
  typedef struct packed {
    logic                 valid;
    logic                 found;      // a room free at start was seen
    logic [ROOM_BITS-1:0] first_idx;  // lowest such room
    logic [TIME_BITS-1:0] min_val;    // earliest free-at time so far
    logic [ROOM_BITS-1:0] min_idx;    // its room, lowest on ties
  } scan_t;

  // booking write-back broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [ROOM_BITS-1:0] idx;
    logic [TIME_BITS-1:0] free_at;
  } upd_t;

endpackage

@@ hdl/lfrs_cell.sv @@
// ----------------------------------------------------------------------------
// lfrs_cell
// One room: holds its free-at time and use count, folds itself into the
// search word passing by and registers the word for the next cell.
// ----------------------------------------------------------------------------
module lfrs_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [lfrs_pkg::ROOM_BITS-1:0]       idx,
  input  logic                                 active,
  input  logic [lfrs_pkg::IN_BITS-1:0]         start,
  input  lfrs_pkg::upd_t                       upd,
  input  lfrs_pkg::scan_t                      tok_in,
  output lfrs_pkg::scan_t                      tok_out,
  output logic [lfrs_pkg::COUNT_BITS-1:0]      uses
);

  logic [lfrs_pkg::TIME_BITS-1:0] free_at;
  lfrs_pkg::scan_t                tok_next;

  // merge this room into the search word; inactive rooms pass it on
  always_comb begin
    tok_next = tok_in;
    if (active) begin
      if (!tok_in.found && (free_at <= lfrs_pkg::TIME_BITS'(start))) begin
        tok_next.found     = 1'b1;
        tok_next.first_idx = idx;
      end
      if (free_at < tok_in.min_val) begin
        tok_next.min_val = free_at;
        tok_next.min_idx = idx;
      end
    end
  end

  // search stage register and room state
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      free_at       <= '0;
      uses          <= '0;
    end else begin
      tok_out <= tok_next;
      if (upd.en && (upd.idx == idx)) begin
        free_at <= upd.free_at;
        if (uses != '1) begin
          uses <= uses + 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/lowest_free_room_scheduler.sv @@
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler
// Books each request into the lowest free room, or the earliest-freeing one.
// ----------------------------------------------------------------------------
// One request is handled at a time: the search word walks a chain of 16 room
// cells, one cell per cycle, then begin/finish is formed, the room is written
// back, the busiest room is updated and the result is loaded once the output
// register is free. A new request is accepted the cycle after the result is
// loaded, even while that result still waits at the output. rooms_in_use
// outside 1..16 is clamped; rooms beyond it still pass the search word along.
// Room times and counts are cleared by reset.
module lowest_free_room_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,   // meeting_start[31:0], meeting_stop[63:32]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [119:0]                      m_tdata,   // room[3:0], begin_time[59:4],
                                                       // finish_time[115:60], busiest_room[119:116]
  output logic [1:0]                        m_tuser,   // delayed[0], time_saturated[1]
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfrs_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int RB = lfrs_pkg::ROOM_BITS;
  localparam int TB = lfrs_pkg::TIME_BITS;
  localparam int IB = lfrs_pkg::IN_BITS;
  localparam int CB = lfrs_pkg::COUNT_BITS;
  localparam int NR = lfrs_pkg::MAX_ROOMS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RANK,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [lfrs_pkg::CFG_BITS-1:0]   rooms_in_use;
  logic [lfrs_pkg::CFG_BITS-1:0]   rooms_eff;
  logic [IB-1:0]                   start_r;
  logic [IB-1:0]                   dur_r;
  logic                            inj_valid;
  logic [RB-1:0]                   room_r;
  logic [TB-1:0]                   begin_r;
  logic [TB-1:0]                   finish_r;
  logic                            late_r;
  logic                            sat_r;
  logic [CB-1:0]                   best_count;
  logic [RB-1:0]                   best_room;

  lfrs_pkg::scan_t                 tok [NR+1];
  lfrs_pkg::upd_t                  upd;
  logic [CB-1:0]                   uses [NR];
  logic [NR-1:0]                   active;
  logic [NR:0]                     tok_valids;

  logic [IB-1:0]                   in_start;
  logic [IB-1:0]                   in_stop;
  logic                            in_beat;
  logic [RB-1:0]                   room_c;
  logic [TB-1:0]                   begin_c;
  logic [TB:0]                     sum_c;
  logic [CB-1:0]                   cnt_sel;
  logic                            cfg_wr;
  logic                            emit_load;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == lfrs_pkg::REG_ROOMS_IN_USE) ? 32'(rooms_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= lfrs_pkg::ROOMS_RESET;
    end else if (cfg_wr && (paddr[2] == lfrs_pkg::REG_ROOMS_IN_USE)) begin
      rooms_in_use <= pwdata[lfrs_pkg::CFG_BITS-1:0];
    end
  end

  // clamp room count to 1..MAX_ROOMS
  always_comb begin
    rooms_eff = rooms_in_use;
    if (rooms_in_use == '0) begin
      rooms_eff = lfrs_pkg::CFG_BITS'(1);
    end else if (rooms_in_use > lfrs_pkg::CFG_BITS'(NR)) begin
      rooms_eff = lfrs_pkg::CFG_BITS'(NR);
    end
  end

  // search word injected at the head of the chain
  always_comb begin
    tok[0].valid     = inj_valid;
    tok[0].found     = 1'b0;
    tok[0].first_idx = '0;
    tok[0].min_val   = '1;
    tok[0].min_idx   = '0;
  end

  assign upd.en      = (state == ST_COMMIT);
  assign upd.idx     = room_r;
  assign upd.free_at = finish_r;

  // chain of room cells
  for (genvar i = 0; i < NR; i++) begin : g_room
    assign active[i] = (lfrs_pkg::CFG_BITS'(i) < rooms_eff);

    lfrs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (RB'(i)),
      .active  (active[i]),
      .start   (start_r),
      .upd     (upd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .uses    (uses[i])
    );
  end

  always_comb begin
    for (int k = 0; k <= NR; k++) begin
      tok_valids[k] = tok[k].valid;
    end
  end

  // input unpacking
  assign in_start = s_tdata[IB-1:0];
  assign in_stop  = s_tdata[2*IB-1:IB];
  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;

  // begin and finish from the search result at the chain tail
  assign room_c  = tok[NR].found ? tok[NR].first_idx : tok[NR].min_idx;
  assign begin_c = tok[NR].found ? TB'(start_r) : tok[NR].min_val;
  assign sum_c   = {1'b0, begin_c} + (TB+1)'(dur_r);
  assign cnt_sel = uses[room_r];

  // result register free or emptying this cycle
  assign emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // control sequence, result register and busiest-room tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      inj_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
      best_count <= '0;
      best_room  <= '0;
    end else begin
      // result valid: set on load, cleared on handshake
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            start_r   <= in_start;
            dur_r     <= (in_stop > in_start) ? (in_stop - in_start) : '0;
            inj_valid <= 1'b1;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          inj_valid <= 1'b0;
          if (tok[NR].valid) begin
            room_r   <= room_c;
            begin_r  <= begin_c;
            late_r   <= !tok[NR].found;
            sat_r    <= sum_c[TB];
            finish_r <= sum_c[TB] ? '1 : sum_c[TB-1:0];
            state    <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state <= ST_RANK;
        end
        ST_RANK: begin
          if ((cnt_sel > best_count) || ((cnt_sel == best_count) && (room_r < best_room))) begin
            best_count <= cnt_sel;
            best_room  <= room_r;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            m_tdata  <= {best_room, finish_r, begin_r, room_r};
            m_tuser  <= {sat_r, late_r};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  // only one request is ever in flight in the chain
  `ASSERT_ALWAYS(a_one_token, $onehot0(tok_valids), "more than one search word in chain")
  // the tail of the chain is only reached while scanning
  `ASSERT_ALWAYS(a_tail_in_scan, !tok[NR].valid || (state == ST_SCAN), "search word outside scan")
  // the booked room has been counted by the time it is ranked
  `ASSERT_ALWAYS(a_rank_count, (state != ST_RANK) || (cnt_sel != '0), "booked room count is zero")
  // the busiest count never drops
  `ASSERT_NEXT(a_best_mono, 1'b1, best_count >= $past(best_count), "busiest count decreased")

endmodule
